// ===== rtl/arcc_pkg.sv =====
// Shared constants and types for the response frame CRC checker.
`default_nettype none
package arcc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h8005;
  localparam logic [7:0]  MIN_FRAME     = 8'd3;
  localparam logic [7:0]  MAX_FRAME_RST = 8'd35;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

  localparam logic REG_MAX_FRAME = 1'b0;

  typedef struct packed {
    logic [7:0] data_out;
    logic [7:0] byte_index;
    logic       last_of_frame;
    logic [1:0] status;
  } arcc_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/arcc_if.sv =====
// Request and response channel interfaces of the frame checker.
`default_nettype none
interface arcc_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface arcc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [7:0] byte_index;
  logic       last_of_frame;
  logic [1:0] status;
  modport source (output valid, output data_out, output byte_index,
                  output last_of_frame, output status, input ready);
  modport sink   (input valid, input data_out, input byte_index,
                  input last_of_frame, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/arcc_crc_byte.sv =====
// Byte-wide CRC-16 update, data bits least significant first.
`default_nettype none
module arcc_crc_byte
  import arcc_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i;
    for (int i = 0; i < 8; i++) begin
      if (byte_i[i] != c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule
`default_nettype wire

// ===== rtl/arcc_frame_eng.sv =====
// Frame state tracking, length check and CRC compare for one byte per cycle while advance_i is high.
`default_nettype none
module arcc_frame_eng
  import arcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] max_len_i,
  output arcc_rsp_t  rsp_o
);

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic        low_ok_q, low_ok_d;
  logic [15:0] crc_seed;
  logic [15:0] crc_next;
  logic [8:0]  pos_plus2;

  // start each frame from a zero seed
  assign crc_seed = (pos_q == 8'd0) ? 16'd0 : crc_q;

  arcc_crc_byte u_crc (
    .crc_i  (crc_seed),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign pos_plus2 = {1'b0, pos_q} + 9'd2;

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    crc_d    = crc_q;
    low_ok_d = low_ok_q;
    rsp_o.data_out      = byte_i;
    rsp_o.byte_index    = pos_q;
    rsp_o.last_of_frame = 1'b0;
    rsp_o.status        = STATUS_OK;
    if (pos_q == 8'd0) begin
      if ((byte_i < MIN_FRAME) || (byte_i > max_len_i)) begin
        rsp_o.last_of_frame = 1'b1;
        rsp_o.status        = STATUS_LEN_ERR;
      end else begin
        len_d    = byte_i;
        crc_d    = crc_next;
        low_ok_d = 1'b0;
        pos_d    = 8'd1;
      end
    end else if (pos_plus2 < {1'b0, len_q}) begin
      crc_d = crc_next;
      pos_d = pos_q + 8'd1;
    end else if (pos_plus2 == {1'b0, len_q}) begin
      low_ok_d = (byte_i == crc_q[7:0]);
      pos_d    = pos_q + 8'd1;
    end else begin
      rsp_o.last_of_frame = 1'b1;
      rsp_o.status = (low_ok_q && (byte_i == crc_q[15:8])) ? STATUS_OK : STATUS_CRC_ERR;
      pos_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 8'd0;
      len_q    <= 8'd0;
      crc_q    <= 16'd0;
      low_ok_q <= 1'b0;
    end else if (advance_i) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      low_ok_q <= low_ok_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/auth_response_frame_crc_checker.sv =====
// Top level of the response frame CRC checker with its register port.
//
//  channel  | dir | handshake     | payload
//  req_i    | in  | valid/ready   | data_byte[7:0]
//  rsp_o    | out | valid/ready   | data_out[7:0] byte_index[7:0] last_of_frame status[1:0]
//  APB      | in  | psel/penable  | paddr[2:0] pwdata[31:0] -> max_frame_bytes at 0x0
//
// One request per cycle sustained while rsp_o is ready; each byte passes from request to
// response through the input register, then the byte-wide CRC network into the result register.
// Reset clears frame state and both valid flags; max_frame_bytes resets to 35.
// A stalled response holds in the result register while one more request waits
// in the input register; ready drops only when both are full.
`default_nettype none
module auth_response_frame_crc_checker
  import arcc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  arcc_req_if.sink     req_i,
  arcc_rsp_if.source   rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic       max_sel;
  logic [7:0] max_len_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  arcc_rsp_t  out_q;
  arcc_rsp_t  eng_rsp;
  logic       advance;
  logic       req_hs;

  // byte lanes within the word are ignored
  assign max_sel = (paddr[2] == REG_MAX_FRAME);
  assign pready  = 1'b1;
  assign prdata  = max_sel ? {24'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_FRAME_RST;
    end else if (psel && penable && pwrite && pready && max_sel) begin
      max_len_q <= pwdata[7:0];
    end
  end

  // advance when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_hs      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_hs) begin
      in_byte_q <= req_i.data_byte;
    end
    if (advance) begin
      out_q <= eng_rsp;
    end
  end

  arcc_frame_eng u_eng (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .rsp_o     (eng_rsp)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.data_out      = out_q.data_out;
  assign rsp_o.byte_index    = out_q.byte_index;
  assign rsp_o.last_of_frame = out_q.last_of_frame;
  assign rsp_o.status        = out_q.status;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != STATUS_OK)) |-> out_q.last_of_frame)
    else $error("error status without end of frame");

  a_len_err_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == STATUS_LEN_ERR)) |-> (out_q.byte_index == 8'd0))
    else $error("length error away from length byte");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (in_valid_q && out_valid_q))
    else $error("request refused with free storage");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced byte lost");

endmodule
`default_nettype wire

// ===== tb/sv/tb_auth_response_frame_crc_checker.sv =====
// Self-checking testbench for the response frame CRC checker: frames in, checked responses out.
module tb_auth_response_frame_crc_checker;
  import arcc_pkg::*;

  localparam int         CLK_PERIOD     = 10;
  localparam int         STALL_LIMIT    = 1000;
  localparam logic [2:0] ADDR_MAX_FRAME = 3'(REG_MAX_FRAME) << 2;
  localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

  typedef enum logic [1:0] {
    CRC_INTACT,
    CRC_BAD_LO,
    CRC_BAD_HI,
    CRC_BAD_BOTH
  } crc_fault_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  arcc_req_if req_if ();
  arcc_rsp_if rsp_if ();

  auth_response_frame_crc_checker u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Frame tracker state, mirrors the checker's view of the byte stream
  logic [7:0]  limit_reg;
  logic [7:0]  frame_pos;
  logic [7:0]  frame_len;
  logic [15:0] crc_run;
  logic        crc_lo_ok;

  arcc_rsp_t pending_rsp_q[$];
  int        sent_count;
  int        err_count;
  int        idle_cycles;
  bit        gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_lsb_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = b[i] ^ crc[15];
      crc = {crc[14:0], 1'b0};
      if (fb) crc = crc ^ CRC_POLY;
    end
    return crc;
  endfunction

  // Advance the frame tracker by one byte and return the response it implies
  function automatic arcc_rsp_t track_frame_byte(input logic [7:0] b);
    arcc_rsp_t r;
    r.data_out      = b;
    r.byte_index    = frame_pos;
    r.last_of_frame = 1'b0;
    r.status        = STATUS_OK;
    if (frame_pos == 8'd0) begin
      if (b < MIN_FRAME || b > limit_reg) begin
        r.last_of_frame = 1'b1;
        r.status        = STATUS_LEN_ERR;
      end else begin
        frame_len = b;
        crc_run   = crc16_lsb_step(16'h0000, b);
        crc_lo_ok = 1'b0;
        frame_pos = 8'd1;
      end
    end else if (int'(frame_pos) + 2 < int'(frame_len)) begin
      crc_run   = crc16_lsb_step(crc_run, b);
      frame_pos = frame_pos + 8'd1;
    end else if (int'(frame_pos) + 2 == int'(frame_len)) begin
      crc_lo_ok = (b == crc_run[7:0]);
      frame_pos = frame_pos + 8'd1;
    end else begin
      r.last_of_frame = 1'b1;
      r.status        = (crc_lo_ok && b == crc_run[15:8]) ? STATUS_OK : STATUS_CRC_ERR;
      frame_pos       = 8'd0;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    err_count++;
    $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h", $time, field, want_v, got_v);
  endtask

  // Response ready with random stall bursts
  initial begin : rsp_ready_drv
    int stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(0, 14);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    arcc_rsp_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected response: expected none, actual data 0x%02h index %0d",
                 $time, rsp_if.data_out, rsp_if.byte_index);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_if.data_out !== want.data_out)
          note_mismatch("data_out", want.data_out, rsp_if.data_out);
        if (rsp_if.byte_index !== want.byte_index)
          note_mismatch("byte_index", want.byte_index, rsp_if.byte_index);
        if (rsp_if.last_of_frame !== want.last_of_frame)
          note_mismatch("last_of_frame", 8'(want.last_of_frame), 8'(rsp_if.last_of_frame));
        if (rsp_if.status !== want.status)
          note_mismatch("status", 8'(want.status), 8'(rsp_if.status));
      end
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_auth_response_frame_crc_checker: FAIL");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= b;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_rsp_q.push_back(track_frame_byte(b));
    sent_count++;
  endtask

  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAX_FRAME) limit_reg = data[7:0];
    @(posedge clk_i);
  endtask

  task automatic check_limit_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_FRAME;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[7:0] !== limit_reg)
      note_mismatch("max_frame_bytes readback", limit_reg, prdata[7:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [7:0] v);
    drain_requests();
    reg_write(ADDR_MAX_FRAME, {24'($urandom), v});
    check_limit_readback();
  endtask

  // Send a frame of the given length; fill below zero means random payload
  task automatic send_frame(input logic [7:0] len, input crc_fault_e fault, input int fill);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = crc16_lsb_step(16'h0000, len);
    push_byte(len);
    for (int i = 3; i < int'(len); i++) begin
      b   = (fill < 0) ? 8'($urandom) : 8'(fill);
      crc = crc16_lsb_step(crc, b);
      push_byte(b);
    end
    if (fault == CRC_BAD_LO || fault == CRC_BAD_BOTH)
      crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
    if (fault == CRC_BAD_HI || fault == CRC_BAD_BOTH)
      crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
    push_byte(crc[7:0]);
    push_byte(crc[15:8]);
  endtask

  task automatic test_reset_limit();
    check_limit_readback();
  endtask

  task automatic test_good_frames();
    send_frame(8'd3, CRC_INTACT, -1);
    send_frame(8'd4, CRC_INTACT, 8'h00);
    send_frame(8'd4, CRC_INTACT, 8'hFF);
  endtask

  task automatic test_length_errors();
    push_byte(8'd0);
    push_byte(8'd1);
    push_byte(8'd2);
    push_byte(MAX_FRAME_RST + 8'd1);
    push_byte(8'hFF);
  endtask

  task automatic test_crc_errors();
    send_frame(8'd3, CRC_BAD_LO, -1);
    send_frame(8'd3, CRC_BAD_HI, -1);
    send_frame(8'd4, CRC_BAD_BOTH, -1);
  endtask

  task automatic test_limit_extremes();
    set_limit(MIN_FRAME);
    push_byte(8'd4);
    send_frame(8'd3, CRC_INTACT, -1);
    set_limit(8'd0);
    push_byte(8'd0);
    push_byte(8'd3);
    set_limit(8'd2);
    push_byte(8'd2);
    push_byte(8'd3);
  endtask

  // A limit written mid-frame must only bite on the next length byte
  task automatic test_limit_mid_frame();
    set_limit(MAX_FRAME_RST);
    push_byte(8'd10);
    repeat (3) push_byte(8'($urandom));
    set_limit(MIN_FRAME);
    repeat (6) push_byte(8'($urandom));
    push_byte(8'd10);
    set_limit(MAX_FRAME_RST);
  endtask

  task automatic test_unmapped_register();
    drain_requests();
    reg_write(ADDR_UNMAPPED, $urandom);
    check_limit_readback();
  endtask

  task automatic test_longest_frame();
    set_limit(8'hFF);
    send_frame(8'hFF, CRC_INTACT, -1);
  endtask

  task automatic test_random_traffic(input logic [7:0] limit, input int n_items);
    int         stop_at;
    int         pick;
    int         cap;
    logic [7:0] len;
    set_limit(limit);
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      // pad a broken frame out with noise until the tracker is back at a length byte
      while (frame_pos != 8'd0) push_byte(8'($urandom));
      pick = $urandom_range(0, 99);
      cap  = (limit_reg > 8'd40 && $urandom_range(0, 29) != 0) ? 40 : int'(limit_reg);
      if (limit_reg < MIN_FRAME || pick >= 88) begin
        push_byte(8'($urandom));
      end else if (pick >= 78) begin
        if (limit_reg == 8'hFF || $urandom_range(0, 1) == 0)
          push_byte(8'($urandom_range(0, 2)));
        else
          push_byte(8'($urandom_range(int'(limit_reg) + 1, 255)));
      end else begin
        len = 8'($urandom_range(3, cap));
        if (pick >= 72)
          push_byte(len);
        else if (pick >= 60)
          send_frame(len, crc_fault_e'($urandom_range(1, 3)), -1);
        else
          send_frame(len, CRC_INTACT, -1);
      end
    end
  endtask

  task automatic test_steady_stream();
    drain_requests();
    gaps_on = 1'b0;
    test_random_traffic(MAX_FRAME_RST, 400);
  endtask

  initial begin
    gaps_on          = 1'b1;
    sent_count       = 0;
    err_count        = 0;
    idle_cycles      = 0;
    limit_reg        = MAX_FRAME_RST;
    frame_pos        = 8'd0;
    frame_len        = 8'd0;
    crc_run          = 16'h0000;
    crc_lo_ok        = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.data_byte = 8'h00;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limit();
    test_good_frames();
    test_length_errors();
    test_crc_errors();
    test_limit_extremes();
    test_limit_mid_frame();
    test_unmapped_register();
    test_random_traffic(MAX_FRAME_RST, 400);
    test_longest_frame();
    test_random_traffic(8'hFF, 200);
    test_random_traffic(8'($urandom_range(3, 60)), 400);
    test_random_traffic(8'($urandom_range(0, 2)), 60);
    test_steady_stream();

    drain_requests();
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && pending_rsp_q.size() == 0) begin
      $display("tb_auth_response_frame_crc_checker: PASS");
    end else begin
      $display("tb_auth_response_frame_crc_checker: FAIL");
    end
    $finish;
  end

endmodule
